>>> hw/rtl/one_shot_timer_slot_table_core_macros.svh
// assertion helpers for the timer slot table
`ifndef ONE_SHOT_TIMER_SLOT_TABLE_CORE_MACROS_SVH
`define ONE_SHOT_TIMER_SLOT_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define OSTS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("osts same-cycle check failed");

// next-cycle implication
`define OSTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("osts next-cycle check failed");

`endif

>>> hw/rtl/osts_pkg.sv
`default_nettype none

package osts_pkg;

   localparam int MAX_SLOTS  = 64;
   localparam int IDX_BITS   = $clog2(MAX_SLOTS);
   localparam int COUNT_BITS = 64;
   localparam int ID_BITS    = 8;
   localparam int SLOT_FIELD_BITS = 4;

   typedef enum logic {
      REQ_TICK     = 1'b0,
      REQ_SCHEDULE = 1'b1
   } req_kind_type;

   typedef enum logic {
      RES_ACK   = 1'b0,
      RES_FIRED = 1'b1
   } res_kind_type;

   typedef struct packed {
      req_kind_type           req_type;
      logic [ID_BITS-1:0]     handler_id;
      logic [COUNT_BITS-1:0]  delay_ticks;
   } req_payload_type;

   typedef struct packed {
      res_kind_type                result_kind;
      logic [SLOT_FIELD_BITS-1:0]  slot_index;
      logic [COUNT_BITS-1:0]       deadline;
      logic [ID_BITS-1:0]          fired_handler;
      logic                        table_full;
      logic                        last;
   } rsp_payload_type;

   // scan token walking down the cell row
   typedef struct packed {
      logic                   active;
      logic                   sched;
      logic                   claimed;
      logic [IDX_BITS-1:0]    index;
      logic [IDX_BITS-1:0]    claim_index;
      logic [COUNT_BITS-1:0]  value;
      logic [ID_BITS-1:0]     handler;
   } probe_type;

   typedef struct packed {
      logic                   hit;
      logic [IDX_BITS-1:0]    index;
      logic [COUNT_BITS-1:0]  deadline;
      logic [ID_BITS-1:0]     handler;
   } hit_type;

endpackage

`default_nettype wire

>>> hw/rtl/osts_stream_if.sv
`default_nettype none

interface osts_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/osts_cell.sv
`default_nettype none

module osts_cell
   import osts_pkg::*;
#(
   parameter int HANDLER_BITS = 8
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      step,
   input  wire probe_type probe_up,
   output probe_type      probe_down,
   output hit_type        hit_out
);

   localparam int STORE_BITS = (HANDLER_BITS < ID_BITS) ? HANDLER_BITS : ID_BITS;

   logic                   valid_ff, valid_in;
   logic [COUNT_BITS-1:0]  deadline_ff, deadline_in;
   logic [STORE_BITS-1:0]  handler_ff, handler_in;
   probe_type              probe_ff, probe_in;
   logic                   claim, match;
   logic [ID_BITS-1:0]     handler_ext;

   assign claim = probe_up.active && probe_up.sched && !probe_up.claimed && !valid_ff;
   assign match = probe_up.active && !probe_up.sched && valid_ff &&
                  (deadline_ff == probe_up.value);

   always_comb begin
      valid_in    = valid_ff;
      deadline_in = deadline_ff;
      handler_in  = handler_ff;
      probe_in       = probe_up;
      probe_in.index = probe_up.index + 1'b1;
      if (claim) begin
         valid_in    = 1'b1;
         deadline_in = probe_up.value;
         handler_in  = probe_up.handler[STORE_BITS-1:0];
         probe_in.claimed     = 1'b1;
         probe_in.claim_index = probe_up.index;
      end
      if (match) begin
         valid_in = 1'b0;
      end
   end

   always_comb begin
      handler_ext = '0;
      handler_ext[STORE_BITS-1:0] = handler_ff;
   end

   always_comb begin
      hit_out = '0;
      if (match) begin
         hit_out.hit      = 1'b1;
         hit_out.index    = probe_up.index;
         hit_out.deadline = deadline_ff;
         hit_out.handler  = handler_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         probe_ff <= '0;
      end else if (step) begin
         valid_ff <= valid_in;
         probe_ff <= probe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         deadline_ff <= deadline_in;
         handler_ff  <= handler_in;
      end
   end

   assign probe_down = probe_ff;

endmodule

`default_nettype wire

>>> hw/rtl/one_shot_timer_slot_table_core.sv
// an accepted request is registered as a scan token that walks the row of slot cells
// one cell per cycle unless a stalled sink holds back a result; results leave through
// the output register; the input reopens only once the token has left the row, so a
// new request is not accepted before the last one is through
// reset: clears the tick count, every slot valid bit, the scan token and the output
// valid flag; slot deadlines and handlers are not cleared
`default_nettype none
`include "one_shot_timer_slot_table_core_macros.svh"

module one_shot_timer_slot_table_core
   import osts_pkg::*;
#(
   parameter int NUM_SLOTS    = 16,
   parameter int HANDLER_BITS = 8
) (
   input wire logic       clock,
   input wire logic       reset,
   osts_stream_if.sink    req_chan,
   osts_stream_if.source  rsp_chan
);

   probe_type              chain [NUM_SLOTS+1];
   hit_type                hits [NUM_SLOTS];
   logic [NUM_SLOTS-1:0]   hit_vec;
   hit_type                sel;
   probe_type              end_probe, new_probe;

   logic [COUNT_BITS-1:0]  tick_ff, tick_inc, sum, sched_dl;
   probe_type              launch_ff;
   logic                   busy_ff;
   logic                   held_v_ff;
   hit_type                held_ff;
   logic                   rsp_v_ff;
   rsp_payload_type        rsp_ff, push_payload;

   logic accept, end_active, rsp_free, push_need, step, push;

   assign chain[0] = launch_ff;

   for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
      osts_cell #(
         .HANDLER_BITS(HANDLER_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .step       (step),
         .probe_up   (chain[g]),
         .probe_down (chain[g+1]),
         .hit_out    (hits[g])
      );
      assign hit_vec[g] = hits[g].hit;
   end

   always_comb begin
      sel = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         sel = hit_type'(sel | hits[i]);
      end
   end

   assign end_probe  = chain[NUM_SLOTS];
   assign end_active = end_probe.active;

   assign req_chan.ready = !busy_ff;
   assign accept = req_chan.valid && !busy_ff;

   assign tick_inc = tick_ff + 64'd1;
   assign sum      = tick_ff + req_chan.payload.delay_ticks;
   assign sched_dl = (sum == '0) ? 64'd1 : sum;

   always_comb begin
      new_probe         = '0;
      new_probe.active  = 1'b1;
      new_probe.sched   = (req_chan.payload.req_type == REQ_SCHEDULE);
      new_probe.value   = new_probe.sched ? sched_dl : tick_inc;
      new_probe.handler = req_chan.payload.handler_id;
   end

   assign rsp_free  = !rsp_v_ff || rsp_chan.ready;
   assign push_need = (sel.hit && held_v_ff) ||
                      (end_active && (end_probe.sched || held_v_ff));
   assign step = rsp_free || !push_need;
   assign push = step && push_need;

   always_comb begin
      push_payload = '0;
      if (end_active && end_probe.sched) begin
         push_payload.result_kind = RES_ACK;
         push_payload.slot_index  = end_probe.claimed ?
                                    end_probe.claim_index[SLOT_FIELD_BITS-1:0] : '0;
         push_payload.deadline    = end_probe.value;
         push_payload.table_full  = !end_probe.claimed;
         push_payload.last        = 1'b1;
      end else begin
         push_payload.result_kind   = RES_FIRED;
         push_payload.slot_index    = held_ff.index[SLOT_FIELD_BITS-1:0];
         push_payload.deadline      = held_ff.deadline;
         push_payload.fired_handler = held_ff.handler;
         push_payload.last          = end_active;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff   <= '0;
         launch_ff <= '0;
         busy_ff   <= 1'b0;
         held_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         if (accept && (req_chan.payload.req_type == REQ_TICK)) begin
            tick_ff <= tick_inc;
         end
         if (accept) begin
            launch_ff <= new_probe;
         end else if (step) begin
            launch_ff.active <= 1'b0;
         end
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (step && end_active) begin
            busy_ff <= 1'b0;
         end
         if (step && sel.hit) begin
            held_v_ff <= 1'b1;
         end else if (step && end_active) begin
            held_v_ff <= 1'b0;
         end
         if (push) begin
            rsp_v_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step && sel.hit) begin
         held_ff <= sel;
      end
      if (push) begin
         rsp_ff <= push_payload;
      end
   end

   assign rsp_chan.valid   = rsp_v_ff;
   assign rsp_chan.payload = rsp_ff;

   `OSTS_ASSERT_IMPL(a_one_hit, clock, reset, 1'b1, $onehot0(hit_vec))
   `OSTS_ASSERT_IMPL(a_idle_empty, clock, reset, !busy_ff, !end_active && !launch_ff.active)
   `OSTS_ASSERT_NEXT(a_accept_launch, clock, reset, accept, busy_ff && launch_ff.active)
   `OSTS_ASSERT_NEXT(a_end_clears, clock, reset, step && end_active, !busy_ff && !held_v_ff)

endmodule

`default_nettype wire
